FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and controller/datapath interface types for the banded
// path counter.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned MAX_VALUE_DEFAULT = 128;

  localparam int unsigned COUNT_W   = 30;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_PRIME     = 30'd1000000007;
  localparam logic [31:0]        COUNT_PRIME_X2  = 32'd2000000014;
  localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd100;

  typedef struct packed {
    logic capture;
    logic load0;
    logic load1;
    logic sweep;
    logic drain;
    logic finish;
    logic emit;
  } bpc_cmd_t;

  typedef struct packed {
    logic sweep_end;
    logic is_last;
    logic out_free;
  } bpc_stat_t;

endpackage

FILE: rtl/bpc_ctrl.sv
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer for the banded path counter: accepts a word, primes the count
// window, sweeps the count memory, folds the last term and emits the result.
// ----------------------------------------------------------------------------
module bpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bpc_pkg::bpc_stat_t stat,
  output bpc_pkg::bpc_cmd_t  cmd
);
  import bpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_LOAD1,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD0;
        end
      end
      ST_LOAD0: begin
        cmd.load0  = 1'b1;
        state_next = ST_LOAD1;
      end
      ST_LOAD1: begin
        cmd.load1  = 1'b1;
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.drain  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.is_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output slot busy");

  a_sweep_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep && stat.sweep_end) |=> cmd.drain)
    else $error("sweep end not followed by drain");
`endif

endmodule

FILE: rtl/bpc_datapath.sv
// ----------------------------------------------------------------------------
// bpc_datapath
// Count memory, three-entry sliding window with modular add, running sum
// and output register of the banded path counter.
// ----------------------------------------------------------------------------
module bpc_datapath #(
  parameter int unsigned MAX_VALUE = bpc_pkg::MAX_VALUE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bpc_pkg::VALUE_W-1:0]       in_fixed_value,
  input  logic                              in_is_last,
  input  logic                              cfg_valid,
  input  logic [bpc_pkg::VALUE_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpc_pkg::COUNT_W-1:0]       out_count,
  input  bpc_pkg::bpc_cmd_t                 cmd,
  output bpc_pkg::bpc_stat_t                stat
);
  import bpc_pkg::*;

  localparam int unsigned AW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
  localparam int unsigned CW = $clog2(MAX_VALUE + 1);
  localparam int unsigned LW = (CW > VALUE_W) ? CW : VALUE_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_VALUE);

  logic [COUNT_W-1:0] count_mem [MAX_VALUE];
  logic [COUNT_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;

  logic [VALUE_W-1:0] max_value;
  logic [VALUE_W-1:0] fixed_value;
  logic               is_last;
  logic [CW-1:0]      limit;
  logic               at_first;
  logic [CW-1:0]      j;
  logic [COUNT_W-1:0] left;
  logic [COUNT_W-1:0] mid;
  logic [COUNT_W-1:0] newq;
  logic [COUNT_W-1:0] acc;

  logic [CW-1:0]      limit_next;
  logic [CW-1:0]      j_plus1;
  logic [CW:0]        j_plus2;
  logic [COUNT_W-1:0] right;
  logic [31:0]        tri_sum;
  logic [COUNT_W-1:0] tri_mod;
  logic [COUNT_W-1:0] wr_val;
  logic [COUNT_W:0]   acc_sum;
  logic [COUNT_W-1:0] acc_next;

  always_comb begin
    if (LW'(max_value) >= MAX_L) begin
      limit_next = CW'(MAX_VALUE);
    end else begin
      limit_next = CW'(max_value);
    end
  end

  assign j_plus1 = j + CW'(1);
  assign j_plus2 = {1'b0, j} + (CW+1)'(2);

  always_comb begin
    rd_addr = '0;
    if (cmd.load1 && MAX_VALUE > 1) begin
      rd_addr = AW'(1);
    end else if (cmd.sweep && j_plus2 < (CW+1)'(MAX_VALUE)) begin
      rd_addr = j_plus2[AW-1:0];
    end
  end

  assign right   = (j_plus1 < limit) ? rd_data : '0;
  assign tri_sum = {2'b00, left} + {2'b00, mid} + {2'b00, right};

  always_comb begin
    if (tri_sum >= COUNT_PRIME_X2) begin
      tri_mod = COUNT_W'(tri_sum - COUNT_PRIME_X2);
    end else if (tri_sum >= {2'b00, COUNT_PRIME}) begin
      tri_mod = COUNT_W'(tri_sum - {2'b00, COUNT_PRIME});
    end else begin
      tri_mod = tri_sum[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (j >= limit) begin
      wr_val = '0;
    end else if (at_first) begin
      wr_val = COUNT_W'(1);
    end else begin
      wr_val = tri_mod;
    end
    if (fixed_value != '0 && LW'(j_plus1) != LW'(fixed_value)) begin
      wr_val = '0;
    end
  end

  assign acc_sum  = {1'b0, acc} + {1'b0, newq};
  assign acc_next = (acc_sum >= {1'b0, COUNT_PRIME}) ?
                    COUNT_W'(acc_sum - {1'b0, COUNT_PRIME}) : acc_sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      count_mem[j[AW-1:0]] <= wr_val;
    end
    rd_data <= count_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fixed_value <= in_fixed_value;
      is_last     <= in_is_last;
    end
    if (cmd.load1) begin
      left <= '0;
      mid  <= rd_data;
    end else if (cmd.sweep) begin
      left <= mid;
      mid  <= rd_data;
    end
    if (cmd.emit) begin
      out_count <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
      limit     <= '0;
      at_first  <= 1'b1;
      j         <= '0;
      newq      <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_value <= cfg_data;
      end
      if (cmd.capture) begin
        limit <= limit_next;
      end
      if (cmd.load0) begin
        j   <= '0;
        acc <= '0;
      end
      if (cmd.load1) begin
        newq <= '0;
      end
      if (cmd.sweep) begin
        j    <= j_plus1;
        newq <= wr_val;
        acc  <= acc_next;
      end
      if (cmd.drain) begin
        acc <= acc_next;
      end
      if (cmd.finish) begin
        at_first <= is_last;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.sweep_end = (j_plus1 == CW'(MAX_VALUE));
  assign stat.is_last   = is_last;
  assign stat.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> (j < CW'(MAX_VALUE)))
    else $error("count write beyond vector");

  a_write_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> (wr_val < COUNT_PRIME))
    else $error("count not reduced");

  a_sum_reduced: assert property (@(posedge clk) disable iff (rst)
    acc < COUNT_PRIME)
    else $error("running sum not reduced");
`endif

endmodule

FILE: rtl/banded_path_count_dp.sv
// ----------------------------------------------------------------------------
// banded_path_count_dp
// Counts arrays with values 1..max_value, neighbors differing by at most one,
// some positions fixed; result modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per array position. tdata[7:0] is the fixed
//   value (0 = free), tlast marks the final position of the array.
//   Master channel: one word per array, sent on the position flagged tlast;
//   tdata[29:0] is the array count.
//   Config channel: cfg_data sets max_value (reset 100); write only when idle.
//   Each word keeps tready low after acceptance until it is processed: the
//   count window is primed, one count memory entry is read and rewritten
//   per cycle in a sweep, and a drain step folds the final term into the
//   running sum; for a final word the result is then registered for output.
//   A finished result is held in an output register; new words are taken
//   while it waits. If a second result is ready before the first is taken,
//   the block stalls until the output slot frees.
//   Reset clears the sequencer, sets max_value to 100 and starts a new array.
// ----------------------------------------------------------------------------
module banded_path_count_dp #(
  parameter int unsigned MAX_VALUE = bpc_pkg::MAX_VALUE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] fixed_value
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]   m_tdata,   // [29:0] array_count
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpc_pkg::VALUE_W-1:0]      cfg_data   // [7:0] max_value
);
  import bpc_pkg::*;

  bpc_cmd_t           cmd;
  bpc_stat_t          stat;
  logic [COUNT_W-1:0] out_count;

  assign cfg_ready = 1'b1;

  bpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpc_datapath #(
    .MAX_VALUE (MAX_VALUE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_fixed_value (s_tdata[VALUE_W-1:0]),
    .in_is_last     (s_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_count      (out_count),
    .cmd            (cmd),
    .stat           (stat)
  );

  assign m_tdata = {{(OUT_DATA_W-COUNT_W){1'b0}}, out_count};

endmodule
